[rtl/detector_pixel_coordinate_map_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the detector pixel coordinate map
// Implication checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_PIXEL_COORDINATE_MAP_ASSERT_SVH
`define DETECTOR_PIXEL_COORDINATE_MAP_ASSERT_SVH

// same-cycle implication
`define DPCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dpcm_pkg.sv]
// ----------------------------------------------------------------------------
// dpcm_pkg
// Constants and lookup tables for the detector pixel coordinate map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpcm_pkg;

  localparam int BOARD_PIX = 48;
  localparam int PANEL_PIX = 192;
  localparam int NUM_CHIPS = 36;

  // config register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BASE = 1'd1;

  localparam logic [9:0] ROW_PIXELS_RST = 10'd192;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } coord_t;

  // channel -> pad, pad = col*8 + row inside the chip
  localparam logic [5:0] PAD_TAB [64] = '{
    6'd59, 6'd51, 6'd43, 6'd35, 6'd34, 6'd42, 6'd50, 6'd58, 6'd25, 6'd33, 6'd41,
    6'd49, 6'd57, 6'd24, 6'd32, 6'd40, 6'd48, 6'd56, 6'd16, 6'd8,  6'd0,  6'd1,
    6'd9,  6'd17, 6'd2,  6'd10, 6'd18, 6'd26, 6'd3,  6'd11, 6'd19, 6'd27, 6'd4,
    6'd12, 6'd20, 6'd28, 6'd5,  6'd13, 6'd21, 6'd29, 6'd6,  6'd14, 6'd22, 6'd7,
    6'd15, 6'd23, 6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd62, 6'd54, 6'd46, 6'd38,
    6'd30, 6'd61, 6'd53, 6'd45, 6'd37, 6'd36, 6'd44, 6'd52, 6'd60
  };

  localparam logic [3:0] SLOT_OF_BOARD [16] = '{
    4'd0, 4'd3, 4'd1, 4'd2, 4'd5, 4'd6, 4'd7, 4'd4,
    4'd10, 4'd9, 4'd8, 4'd11, 4'd15, 4'd12, 4'd14, 4'd13
  };

  // quarter turns per slot
  localparam logic [1:0] SLOT_TURN [16] = '{
    2'd3, 2'd1, 2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2,
    2'd0, 2'd0, 2'd2, 2'd2, 2'd3, 2'd1, 2'd3, 2'd1
  };

  localparam logic [1:0] SLOT_OFS_X [16] = '{
    2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0,
    2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0
  };

  localparam logic [1:0] SLOT_OFS_Y [16] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3
  };

endpackage

[rtl/dpcm_if.sv]
// ----------------------------------------------------------------------------
// dpcm_if
// Valid/ready channels carrying input and result words of the coordinate map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpcm_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] board_id;
  logic [5:0] chip;
  logic [5:0] channel;

  modport source (output valid, output board_id, output chip, output channel,
                  input ready);
  modport sink (input valid, input board_id, input chip, input channel,
                output ready);
endinterface

interface dpcm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  x_coord;
  logic [7:0]  y_coord;
  logic [24:0] pixel_id;
  logic        invalid;

  modport source (output valid, output x_coord, output y_coord, output pixel_id,
                  output invalid, input ready);
  modport sink (input valid, input x_coord, input y_coord, input pixel_id,
                input invalid, output ready);
endinterface

[rtl/detector_pixel_coordinate_map.sv]
// ----------------------------------------------------------------------------
// detector_pixel_coordinate_map
// Maps board/chip/channel of a readout word to panel x/y and a pixel number.
// Stages: 2 register stages (input reg, result reg); an accepted input word
//   moves from stage A into the result register once that is free or taken.
// Throughput: one word per cycle; stage A waits while the result register is
//   full and not taken, and input ready drops only when both stages are full.
// Reset: rst_n synchronous active low; clears stage valids, row_pixels to
//   192 and pixel_base to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module detector_pixel_coordinate_map (
  input  logic                              clk,
  input  logic                              rst_n,
  dpcm_in_if.sink                           in_ch,
  dpcm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "detector_pixel_coordinate_map_assert.svh"

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [9:0]  row_pixels_r;
  logic [23:0] pixel_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixels_r <= dpcm_pkg::ROW_PIXELS_RST;
      pixel_base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpcm_pkg::REG_ROW_PIXELS: row_pixels_r <= cfg_data[9:0];
        dpcm_pkg::REG_PIXEL_BASE: pixel_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: both stages move when the result register is free or taken.
  // Stage A accepts a new word whenever it is empty or moving on.
  // --------------------------------------------------------------------------
  logic a_valid_r;
  logic out_valid_r;
  logic adv;
  logic in_take;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !a_valid_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic [3:0] a_board_r;
  logic [5:0] a_chip_r;
  logic [5:0] a_chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_board_r <= in_ch.board_id;
      a_chip_r  <= in_ch.chip;
      a_chan_r  <= in_ch.channel;
    end
  end

  // --------------------------------------------------------------------------
  // Mapping logic between stage A and the result register
  // --------------------------------------------------------------------------

  // quarter-turn rotation on an n by n grid
  function automatic dpcm_pkg::coord_t turn_q(input logic [7:0] n, input logic [1:0] q,
                                              input dpcm_pkg::coord_t c);
    dpcm_pkg::coord_t r;
    r = c;
    case (q)
      2'd1: begin
        r.x = c.y;
        r.y = 8'(n - 8'd1 - c.x);
      end
      2'd2: begin
        r.x = 8'(n - 8'd1 - c.x);
        r.y = 8'(n - 8'd1 - c.y);
      end
      2'd3: begin
        r.x = 8'(n - 8'd1 - c.y);
        r.y = c.x;
      end
      default: ;
    endcase
    return r;
  endfunction

  // chip column = chip / 6, meaningful for chips below 36
  function automatic logic [2:0] chip_col(input logic [5:0] chip);
    logic [2:0] col;
    if (chip >= 6'd30)      col = 3'd5;
    else if (chip >= 6'd24) col = 3'd4;
    else if (chip >= 6'd18) col = 3'd3;
    else if (chip >= 6'd12) col = 3'd2;
    else if (chip >= 6'd6)  col = 3'd1;
    else                    col = 3'd0;
    return col;
  endfunction

  logic             chip_bad;
  logic [5:0]       pad;
  logic [2:0]       col;
  logic [2:0]       row_idx;
  logic [2:0]       row_sel;
  logic [2:0]       pad_x;
  logic [2:0]       pad_y;
  logic [5:0]       brd_x;
  logic [5:0]       brd_y;
  logic [3:0]       slot;
  dpcm_pkg::coord_t brd_c;
  dpcm_pkg::coord_t brd_t;
  dpcm_pkg::coord_t pan_c;
  dpcm_pkg::coord_t pan_t;
  logic [17:0]      x_prod;
  logic [24:0]      pix;

  always_comb begin
    chip_bad = (a_chip_r >= 6'(dpcm_pkg::NUM_CHIPS));
    pad      = dpcm_pkg::PAD_TAB[a_chan_r];
    col      = chip_col(a_chip_r);
    row_idx  = 3'(a_chip_r - 6'(col) * 6'd6);

    // odd columns are mounted flipped: mirror pad and chip order
    pad_x   = col[0] ? ~pad[5:3] : pad[5:3];
    pad_y   = col[0] ? ~pad[2:0] : pad[2:0];
    row_sel = col[0] ? 3'(3'd5 - row_idx) : row_idx;

    brd_x = {col, pad_x};
    brd_y = {row_sel, pad_y};

    // mirror in x on the board
    brd_c.x = 8'(dpcm_pkg::BOARD_PIX - 1) - {2'b00, brd_x};
    brd_c.y = {2'b00, brd_y};

    slot  = dpcm_pkg::SLOT_OF_BOARD[a_board_r];
    brd_t = turn_q(8'(dpcm_pkg::BOARD_PIX), dpcm_pkg::SLOT_TURN[slot], brd_c);

    // place the board on the panel (offset * 48)
    pan_c.x = brd_t.x + 8'(dpcm_pkg::SLOT_OFS_X[slot]) * 8'(dpcm_pkg::BOARD_PIX);
    pan_c.y = brd_t.y + 8'(dpcm_pkg::SLOT_OFS_Y[slot]) * 8'(dpcm_pkg::BOARD_PIX);

    // whole panel rotated by 270 degrees
    pan_t = turn_q(8'(dpcm_pkg::PANEL_PIX), 2'd3, pan_c);

    x_prod = 18'(pan_t.x) * 18'(row_pixels_r);
    pix    = 25'(x_prod) + 25'(pan_t.y) + 25'(pixel_base_r);
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [7:0]  out_x_r;
  logic [7:0]  out_y_r;
  logic [24:0] out_pix_r;
  logic        out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      out_x_r   <= chip_bad ? '0 : pan_t.x;
      out_y_r   <= chip_bad ? '0 : pan_t.y;
      out_pix_r <= chip_bad ? '0 : pix;
      out_inv_r <= chip_bad;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.x_coord  = out_x_r;
  assign out_ch.y_coord  = out_y_r;
  assign out_ch.pixel_id = out_pix_r;
  assign out_ch.invalid  = out_inv_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DPCM_ASSERT_NOW(a_inv_zero, out_valid_r && out_inv_r, out_x_r == 8'd0 && out_y_r == 8'd0 && out_pix_r == 25'd0, "invalid word with nonzero fields")
  `DPCM_ASSERT_NOW(a_coord_range, out_valid_r && !out_inv_r, out_x_r < 8'd192 && out_y_r < 8'd192, "coordinate off panel")
  `DPCM_ASSERT_NEXT(a_in_lands, in_take, a_valid_r, "accepted word not held in stage A")
  `DPCM_ASSERT_NEXT(a_out_lands, a_valid_r && adv, out_valid_r, "stage A word lost on advance")

endmodule
